@@ rtl/hsw_pkg.sv @@
package hsw_pkg;

  localparam int unsigned HumW     = 7;
  localparam int unsigned SpW      = 7;
  localparam int unsigned MarginW  = 8;
  localparam int unsigned BandW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSetpoint    = 2'd0,
    CfgUpperMargin = 2'd1,
    CfgLowerMargin = 2'd2
  } cfg_reg_e;

endpackage

@@ rtl/hysteresis_switch_with_timed_fallback.sv @@
// Humidity on/off hysteresis switch with a timed fallback duty cycle.
//
// Channels (valid/ready, one transfer per rising edge with both high):
//   in  : humidity_i, sensor_failed_i, now_ms_i
//   out : drive_on_o, band_low_o, band_high_o (one result per input item)
//   cfg : cfg_index_i selects setpoint (0), upper margin (1), lower
//         margin (2); other indexes are ignored. cfg_ready_o is always high.
//         Write configuration only while the block holds no item.
// Path: an item taken on the in channel passes the input register, then the
//   result register, whose outputs drive the out channel.
// Throughput: one item per cycle unless stalled. The state update (one 32-bit
//   subtract and compare against the learned duration) sits in the single
//   combinational step between the input register and the result register.
// Stall: while out_ready_i is low the result register holds; the input
//   register still takes one more item, then in_ready_o drops.
// Reset: drive off, phase start and learned on/off times zero, all
//   configuration registers zero, both stages empty.
module hysteresis_switch_with_timed_fallback (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hsw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [hsw_pkg::CfgDataW-1:0]     cfg_data_i,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hsw_pkg::HumW-1:0]         humidity_i,
  input  logic                             sensor_failed_i,
  input  logic [hsw_pkg::TimeW-1:0]        now_ms_i,
  // results
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             drive_on_o,
  output logic [hsw_pkg::BandW-1:0]        band_low_o,
  output logic [hsw_pkg::BandW-1:0]        band_high_o
);

  // Configuration registers
  logic [hsw_pkg::SpW-1:0]     setpoint_q;
  logic [hsw_pkg::MarginW-1:0] upper_margin_q;
  logic [hsw_pkg::MarginW-1:0] lower_margin_q;

  // Controller state
  logic                        held_on_q, held_on_d;
  logic [hsw_pkg::TimeW-1:0]   phase_start_q, phase_start_d;
  logic [hsw_pkg::TimeW-1:0]   on_time_q, on_time_d;
  logic [hsw_pkg::TimeW-1:0]   off_time_q, off_time_d;

  // Input register
  logic                        in_vld_q;
  logic [hsw_pkg::HumW-1:0]    hum_q;
  logic                        failed_q;
  logic [hsw_pkg::TimeW-1:0]   now_q;

  // Result register
  logic                        out_vld_q;
  logic                        drive_q;
  logic [hsw_pkg::BandW-1:0]   band_low_q, band_high_q;

  logic                        advance;
  logic [hsw_pkg::BandW-1:0]   band_low, band_high;
  logic [hsw_pkg::BandW-1:0]   sp_ext, hum_ext;
  logic [hsw_pkg::BandW:0]     hi_sum;
  logic [hsw_pkg::TimeW-1:0]   elapsed, limit;

  // Stage handshake: the input register empties into the result register
  // whenever the result register is free or being taken this cycle.
  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q     <= '0;
      upper_margin_q <= '0;
      lower_margin_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hsw_pkg::CfgSetpoint:    setpoint_q     <= cfg_data_i[hsw_pkg::SpW-1:0];
        hsw_pkg::CfgUpperMargin: upper_margin_q <= cfg_data_i[hsw_pkg::MarginW-1:0];
        hsw_pkg::CfgLowerMargin: lower_margin_q <= cfg_data_i[hsw_pkg::MarginW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Band edges, saturated at both ends
  assign sp_ext    = {{(hsw_pkg::BandW-hsw_pkg::SpW){1'b0}}, setpoint_q};
  assign hum_ext   = {{(hsw_pkg::BandW-hsw_pkg::HumW){1'b0}}, hum_q};
  assign band_low  = (sp_ext > lower_margin_q) ? (sp_ext - lower_margin_q) : '0;
  assign hi_sum    = {1'b0, sp_ext} + {1'b0, upper_margin_q};
  assign band_high = hi_sum[hsw_pkg::BandW] ? '1 : hi_sum[hsw_pkg::BandW-1:0];

  // Elapsed time wraps modulo 2^32
  assign elapsed = now_q - phase_start_q;
  assign limit   = held_on_q ? on_time_q : off_time_q;

  always_comb begin
    held_on_d     = held_on_q;
    phase_start_d = phase_start_q;
    on_time_d     = on_time_q;
    off_time_d    = off_time_q;
    if (!failed_q) begin
      priority if (hum_ext < band_low) begin
        // below band: off phase ends, learn its length
        off_time_d    = elapsed;
        phase_start_d = now_q;
        held_on_d     = 1'b1;
      end else if (hum_ext > band_high) begin
        on_time_d     = elapsed;
        phase_start_d = now_q;
        held_on_d     = 1'b0;
      end else begin
        // inside band: hold
      end
    end else if (elapsed > limit) begin
      // fallback: learned phase expired, toggle
      held_on_d     = !held_on_q;
      phase_start_d = now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_on_q     <= 1'b0;
      phase_start_q <= '0;
      on_time_q     <= '0;
      off_time_q    <= '0;
    end else if (advance) begin
      held_on_q     <= held_on_d;
      phase_start_q <= phase_start_d;
      on_time_q     <= on_time_d;
      off_time_q    <= off_time_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hum_q    <= humidity_i;
      failed_q <= sensor_failed_i;
      now_q    <= now_ms_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q     <= held_on_d;
      band_low_q  <= band_low;
      band_high_q <= band_high;
    end
  end

  assign out_valid_o = out_vld_q;
  assign drive_on_o  = drive_q;
  assign band_low_o  = band_low_q;
  assign band_high_o = band_high_q;

endmodule

@@ rtl/hsw_checker.sv @@
module hsw_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             drive_on_o,
  input logic [hsw_pkg::BandW-1:0]        band_low_o,
  input logic [hsw_pkg::BandW-1:0]        band_high_o
);

  logic       in_xfer, out_xfer;
  logic [2:0] inflight_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + {2'b00, in_xfer} - {2'b00, out_xfer};
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_on_o)
      && $stable(band_low_o) && $stable(band_high_o))
    else $error("stalled result changed");

  // saturated edges always bracket the setpoint
  a_band_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> band_low_o <= band_high_o)
    else $error("band_low above band_high");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result without a pending item");

  // two storage slots: input register and result register
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd2)
    else $error("more items in flight than slots");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind hysteresis_switch_with_timed_fallback hsw_checker u_hsw_checker (.*);

@@ bench/hysteresis_switch_with_timed_fallback_tb.sv @@
`timescale 1ns / 100ps

module hysteresis_switch_with_timed_fallback_tb;
  import hsw_pkg::*;

  // Ends the run if the bench hangs. The slowest correct run stays well below this:
  // roughly 770 transfers, each with the longest idle stretch that idle_len gives on
  // both the input and the output.
  localparam int unsigned CycleLimit = 500_000;
  // Index that decodes to no register; writes to it must leave the setup unchanged.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int unsigned NumPhases = 12;
  localparam int unsigned ReadingsPerPhase = 62;

  typedef struct packed {
    logic [HumW-1:0]  humidity;
    logic             failed;
    logic [TimeW-1:0] now_ms;
  } reading_t;

  typedef struct packed {
    logic             drive_on;
    logic [BandW-1:0] band_low;
    logic [BandW-1:0] band_high;
  } drive_cmd_t;

  typedef struct packed {
    logic [BandW-1:0] lo;
    logic [BandW-1:0] hi;
  } band_t;

  typedef enum logic {RowReading, RowRegWrite} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_data;
    reading_t            rd;
    logic                typed;   // 1: the drive command in the row is checked as is
    drive_cmd_t          cmd;
  } plan_row_t;

  localparam reading_t   NoRd  = '0;
  localparam drive_cmd_t NoCmd = '0;

  // Directed plan. A register write row first waits until the block is idle.
  // Rows without a typed command are checked against the predictor.
  localparam int unsigned PlanLen = 35;
  localparam plan_row_t Plan [PlanLen] = '{
    // reset setup: both band edges are 0
    '{RowReading, CfgSetpoint, 8'h00, '{7'd0, 1'b0, 32'd0}, 1'b1, '{1'b0, 8'd0, 8'd0}},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd127, 1'b0, 32'd100}, 1'b1, '{1'b0, 8'd0, 8'd0}},
    // fallback with a learned off time of zero: equal elapsed holds, one more ms toggles
    '{RowReading, CfgSetpoint, 8'h00, '{7'd0, 1'b1, 32'd100}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd0, 1'b1, 32'd101}, 1'b0, NoCmd},
    // band from 40 to 60
    '{RowRegWrite, CfgSetpoint, 8'd50, NoRd, 1'b0, NoCmd},
    '{RowRegWrite, CfgUpperMargin, 8'd10, NoRd, 1'b0, NoCmd},
    '{RowRegWrite, CfgLowerMargin, 8'd10, NoRd, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd39, 1'b0, 32'd300}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd50, 1'b0, 32'd350}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd61, 1'b0, 32'd400}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd39, 1'b0, 32'd700}, 1'b0, NoCmd},
    // learned on time 100, off time 300: check the boundary of both phases
    '{RowReading, CfgSetpoint, 8'h00, '{7'd100, 1'b1, 32'd800}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd100, 1'b1, 32'd801}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd0, 1'b1, 32'd1101}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd0, 1'b1, 32'd1102}, 1'b0, NoCmd},
    // time wraps past 2^32 between the two switches
    '{RowReading, CfgSetpoint, 8'h00, '{7'd61, 1'b0, 32'hFFFF_FFF0}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd39, 1'b0, 32'h0000_0010}, 1'b0, NoCmd},
    // readings on the band edges hold
    '{RowReading, CfgSetpoint, 8'h00, '{7'd40, 1'b0, 32'h0000_0020}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd60, 1'b0, 32'h0000_0030}, 1'b0, NoCmd},
    // all registers at full scale: low edge clamps to 0, high edge saturates
    '{RowRegWrite, CfgSetpoint, 8'hFF, NoRd, 1'b0, NoCmd},
    '{RowRegWrite, CfgUpperMargin, 8'hFF, NoRd, 1'b0, NoCmd},
    '{RowRegWrite, CfgLowerMargin, 8'hFF, NoRd, 1'b0, NoCmd},
    '{RowRegWrite, CfgSpare, 8'hAA, NoRd, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd127, 1'b1, 32'hFFFF_FFFF}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd0, 1'b0, 32'h7FFF_FFFF}, 1'b0, NoCmd},
    // high edge saturates while the low edge sits at the setpoint
    '{RowRegWrite, CfgSetpoint, 8'd100, NoRd, 1'b0, NoCmd},
    '{RowRegWrite, CfgUpperMargin, 8'd200, NoRd, 1'b0, NoCmd},
    '{RowRegWrite, CfgLowerMargin, 8'd0, NoRd, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd99, 1'b0, 32'h8000_0000}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd127, 1'b0, 32'h8000_0001}, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd64, 1'b1, 32'h8000_0002}, 1'b0, NoCmd},
    // back to a zero band: any humidity above 0 switches off
    '{RowRegWrite, CfgSetpoint, 8'd0, NoRd, 1'b0, NoCmd},
    '{RowRegWrite, CfgUpperMargin, 8'd0, NoRd, 1'b0, NoCmd},
    '{RowRegWrite, CfgLowerMargin, 8'd0, NoRd, 1'b0, NoCmd},
    '{RowReading, CfgSetpoint, 8'h00, '{7'd1, 1'b0, 32'h8000_0003}, 1'b1, '{1'b0, 8'd0, 8'd0}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [HumW-1:0]     humidity_i = '0;
  logic                sensor_failed_i = 1'b0;
  logic [TimeW-1:0]    now_ms_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                drive_on_o;
  logic [BandW-1:0]    band_low_o;
  logic [BandW-1:0]    band_high_o;

  // Predictor copy of the registers and the controller state, all at reset values.
  logic [SpW-1:0]     reg_setpoint = '0;
  logic [MarginW-1:0] reg_upper = '0;
  logic [MarginW-1:0] reg_lower = '0;
  logic               ctl_held_on = 1'b0;
  logic [TimeW-1:0]   ctl_phase_start = '0;
  logic [TimeW-1:0]   ctl_on_dur = '0;
  logic [TimeW-1:0]   ctl_off_dur = '0;

  drive_cmd_t cmd_due_q[$];   // drive commands still owed by the block, oldest first

  bit          in_gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_reg_writes = 0;
  int unsigned n_fallback = 0;
  int unsigned n_timed_toggle = 0;

  hysteresis_switch_with_timed_fallback i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .humidity_i     (humidity_i),
    .sensor_failed_i(sensor_failed_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_on_o     (drive_on_o),
    .band_low_o     (band_low_o),
    .band_high_o    (band_high_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle stretch length: none unless enabled and the dice say so, mostly short,
  // sometimes long.
  function automatic int unsigned idle_len(input bit enabled, input int unsigned pct);
    if (!enabled || $urandom_range(99) >= pct) return 0;
    if ($urandom_range(99) < 80) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  // Band edges from the current setup: low clamps at 0, high saturates at 255.
  function automatic band_t band_edges();
    band_t            b;
    logic [BandW:0]   sum;
    b.lo = ({1'b0, reg_setpoint} > reg_lower) ? {1'b0, reg_setpoint} - reg_lower : '0;
    sum  = {2'b00, reg_setpoint} + {1'b0, reg_upper};
    b.hi = sum[BandW] ? '1 : sum[BandW-1:0];
    return b;
  endfunction

  // One controller step: hysteresis on a good reading, replay of the learned
  // on/off durations on a failed one. Elapsed time wraps modulo 2^32.
  function automatic drive_cmd_t humidifier_step(input reading_t rd);
    band_t            b;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] hold_for;
    drive_cmd_t       cmd;
    b       = band_edges();
    elapsed = rd.now_ms - ctl_phase_start;
    if (!rd.failed) begin
      if ({1'b0, rd.humidity} < b.lo) begin
        ctl_off_dur     = elapsed;
        ctl_phase_start = rd.now_ms;
        ctl_held_on     = 1'b1;
      end else if ({1'b0, rd.humidity} > b.hi) begin
        ctl_on_dur      = elapsed;
        ctl_phase_start = rd.now_ms;
        ctl_held_on     = 1'b0;
      end
    end else begin
      n_fallback++;
      hold_for = ctl_held_on ? ctl_on_dur : ctl_off_dur;
      // strictly longer than the learned phase before toggling
      if (elapsed > hold_for) begin
        ctl_held_on     = !ctl_held_on;
        ctl_phase_start = rd.now_ms;
        n_timed_toggle++;
      end
    end
    cmd.drive_on  = ctl_held_on;
    cmd.band_low  = b.lo;
    cmd.band_high = b.hi;
    return cmd;
  endfunction

  // Drives one reading. Valid stays high from the previous transfer when there is
  // no gap, so it is never lowered and raised in the same step.
  task automatic send_reading(input reading_t rd, input bit typed, input drive_cmd_t typed_cmd);
    int unsigned gap;
    drive_cmd_t  due;
    gap = idle_len(in_gaps_on, 45);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    humidity_i      <= rd.humidity;
    sensor_failed_i <= rd.failed;
    now_ms_i        <= rd.now_ms;
    do @(posedge clk_i); while (!in_ready_o);
    // transfer at this edge: predictor state moves in step with the block
    due = humidifier_step(rd);
    cmd_due_q.push_back(typed ? typed_cmd : due);
    n_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgSetpoint:    reg_setpoint = data[SpW-1:0];
      CfgUpperMargin: reg_upper = data;
      CfgLowerMargin: reg_lower = data;
      default: ;
    endcase
    n_reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every owed command is out and the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (cmd_due_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Output back-pressure: random stall stretches, switched off for some phases.
  always @(posedge clk_i) begin
    int unsigned len;
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      len = idle_len(stall_on, 25);
      out_ready_i <= (len == 0);
      stall_left  <= (len == 0) ? 0 : len - 1;
    end
  end

  // Result checker: each transfer is compared with the oldest owed command.
  always @(posedge clk_i) begin
    drive_cmd_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cmd_due_q.size() == 0) begin
        $error("unexpected result: drive_on %0d band_low %0d band_high %0d",
               drive_on_o, band_low_o, band_high_o);
        mismatches++;
      end else begin
        want = cmd_due_q.pop_front();
        n_checked++;
        if (drive_on_o !== want.drive_on) begin
          $error("drive_on: expected %0d, got %0d", want.drive_on, drive_on_o);
          mismatches++;
        end
        if (band_low_o !== want.band_low) begin
          $error("band_low: expected %0d, got %0d", want.band_low, band_low_o);
          mismatches++;
        end
        if (band_high_o !== want.band_high) begin
          $error("band_high: expected %0d, got %0d", want.band_high, band_high_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d commands still owed", cycles, cmd_due_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    plan_row_t           row;
    reading_t            rd;
    band_t               b;
    bit                  failing;
    logic [TimeW-1:0]    t;
    logic [CfgDataW-1:0] sp_w, up_w, lo_w;
    int unsigned         hum_lo, hum_hi, pick;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed plan
    foreach (Plan[i]) begin
      row = Plan[i];
      if (row.kind == RowRegWrite) begin
        settle();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_reading(row.rd, row.typed, row.cmd);
      end
    end

    // Random phases: new setup each phase, then a stream of readings whose time
    // mostly creeps forward and whose humidity mostly hovers around the band, so
    // both switching directions and the timed fallback get exercised.
    t       = Plan[PlanLen-1].rd.now_ms;
    failing = 1'b0;
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      in_gaps_on = ($urandom_range(3) != 0);
      stall_on  <= ($urandom_range(3) != 0);
      case (p)
        0: begin sp_w = 8'd0;   up_w = 8'd0;   lo_w = 8'd0;   end
        1: begin sp_w = 8'hFF;  up_w = 8'hFF;  lo_w = 8'hFF;  end
        2: begin sp_w = 8'd100; up_w = 8'd0;   lo_w = 8'd0;   end
        3: begin sp_w = 8'd0;   up_w = 8'hFF;  lo_w = 8'hFF;  end
        default: begin
          sp_w = CfgDataW'($urandom_range(255));
          up_w = CfgDataW'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                    : $urandom_range(20));
          lo_w = CfgDataW'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                    : $urandom_range(20));
        end
      endcase
      write_reg(CfgSetpoint, sp_w);
      write_reg(CfgUpperMargin, up_w);
      write_reg(CfgLowerMargin, lo_w);
      if (p % 4 == 3) write_reg(CfgSpare, CfgDataW'($urandom_range(255)));

      b      = band_edges();
      hum_lo = (b.lo > 4) ? b.lo - 4 : 0;
      hum_hi = (b.hi + 4 > 127) ? 127 : b.hi + 4;
      repeat (ReadingsPerPhase) begin
        // sensor failures come in runs
        if ($urandom_range(99) < 8) failing = !failing;
        pick = $urandom_range(99);
        if (pick < 70)      t = t + $urandom_range(400);
        else if (pick < 90) t = t + $urandom_range(5000, 400);
        else if (pick < 95) t = $urandom;
        rd.failed   = failing;
        rd.now_ms   = t;
        rd.humidity = HumW'(($urandom_range(99) < 75) ? $urandom_range(hum_hi, hum_lo)
                                                      : $urandom_range(127));
        send_reading(rd, 1'b0, NoCmd);
      end
    end

    settle();
    $display("%0d readings, %0d commands checked, %0d register writes, %0d phases",
             n_sent, n_checked, n_reg_writes, NumPhases);
    $display("%0d readings on a failed sensor, %0d timed toggles", n_fallback, n_timed_toggle);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
